// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DFP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("delimited field parser assertion failed");

// Clocked assertion that also holds across reset.
`define DFP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("delimited field parser assertion failed");

`endif

// ===== rtl/dfp_pkg.sv =====
// Types, character codes and parse-step functions of the delimited field parser.
`default_nettype none

package dfp_pkg;

   // Characters widened by one bit; the top bit marks end of input.
   localparam logic [8:0] CH_EOF    = 9'h100;
   localparam logic [8:0] CH_COMMA  = 9'h02C;
   localparam logic [8:0] CH_SEMI   = 9'h03B;
   localparam logic [8:0] CH_TAB    = 9'h009;
   localparam logic [8:0] CH_LF     = 9'h00A;
   localparam logic [8:0] CH_CR     = 9'h00D;
   localparam logic [8:0] CH_QUOTE  = 9'h022;
   localparam logic [8:0] CH_BSLASH = 9'h05C;
   localparam logic [8:0] CH_SPACE  = 9'h020;

   // Escape letters and their decoded bytes.
   localparam logic [8:0] CH_LOW_B  = 9'h062;
   localparam logic [8:0] CH_LOW_F  = 9'h066;
   localparam logic [8:0] CH_LOW_N  = 9'h06E;
   localparam logic [8:0] CH_LOW_T  = 9'h074;
   localparam logic [8:0] CH_LOW_R  = 9'h072;
   localparam logic [8:0] CH_LOW_V  = 9'h076;
   localparam logic [7:0] ESC_BS    = 8'h08;
   localparam logic [7:0] ESC_FF    = 8'h0C;
   localparam logic [7:0] ESC_LF    = 8'h0A;
   localparam logic [7:0] ESC_HT    = 8'h09;
   localparam logic [7:0] ESC_CR    = 8'h0D;
   localparam logic [7:0] ESC_VT    = 8'h0B;
   localparam logic [7:0] ESC_NONE  = 8'h00;

   // Terminator codes.
   localparam logic [2:0] END_OTHER = 3'd0;
   localparam logic [2:0] END_COMMA = 3'd1;
   localparam logic [2:0] END_SEMI  = 3'd2;
   localparam logic [2:0] END_TAB   = 3'd3;
   localparam logic [2:0] END_EOI   = 3'd4;

   // Delimiter selections.
   localparam logic [1:0] DELIM_LF    = 2'd0;
   localparam logic [1:0] DELIM_COMMA = 2'd1;
   localparam logic [1:0] DELIM_SEMI  = 2'd2;
   localparam logic [1:0] DELIM_TAB   = 2'd3;

   // Control register indexes.
   localparam logic [1:0] CSR_ESCAPES = 2'd0;
   localparam logic [1:0] CSR_TABLE   = 2'd1;
   localparam logic [1:0] CSR_DELIM   = 2'd2;

   // Result queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_UNQ   = 5'b00010,
      PH_QUO   = 5'b00100,
      PH_QSEEN = 5'b01000,
      PH_TRAIL = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       escapes_enabled;
      logic       table_mode;
      logic [1:0] delimiter_select;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_field_end;
      logic [2:0] end_code;
   } res_type;

   // One queue entry: all results of one accepted item.
   typedef struct packed {
      res_type r0;
      logic    r1_valid;
      res_type r1;
   } entry_type;

   typedef struct packed {
      phase_type phase;
      logic      emit;
      res_type   res;
   } step_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   function automatic logic [8:0] delim_char(input logic [1:0] sel);
      logic [8:0] d;
      unique case (sel)
         DELIM_LF:    d = CH_LF;
         DELIM_COMMA: d = CH_COMMA;
         DELIM_SEMI:  d = CH_SEMI;
         DELIM_TAB:   d = CH_TAB;
         default:     d = CH_COMMA;
      endcase
      return d;
   endfunction

   function automatic logic [2:0] classify(input logic [8:0] c);
      logic [2:0] code;
      if (c == CH_COMMA)
         code = END_COMMA;
      else if (c == CH_SEMI)
         code = END_SEMI;
      else if (c == CH_TAB)
         code = END_TAB;
      else if (c == CH_EOF)
         code = END_EOI;
      else
         code = END_OTHER;
      return code;
   endfunction

   // Decoded byte of an escape letter, ESC_NONE when the letter is unknown.
   function automatic logic [7:0] esc_decode(input logic [8:0] c);
      logic [7:0] d;
      if (c == CH_LOW_B)
         d = ESC_BS;
      else if (c == CH_LOW_F)
         d = ESC_FF;
      else if (c == CH_LOW_N)
         d = ESC_LF;
      else if (c == CH_LOW_T)
         d = ESC_HT;
      else if (c == CH_LOW_R)
         d = ESC_CR;
      else if (c == CH_LOW_V)
         d = ESC_VT;
      else if (c == CH_BSLASH)
         d = CH_BSLASH[7:0];
      else
         d = ESC_NONE;
      return d;
   endfunction

   // Character after a field body or a trailing blank.
   function automatic step_type finish_step(input logic [8:0] c, input cfg_type cfg);
      step_type st;
      logic     tab_active;
      tab_active = cfg.table_mode && (cfg.delimiter_select == DELIM_TAB);
      st = '0;
      if (c == CH_SPACE || (c == CH_TAB && !tab_active)) begin
         st.phase = PH_TRAIL;
      end else begin
         st.phase            = PH_LEAD;
         st.emit             = 1'b1;
         st.res.is_field_end = 1'b1;
         st.res.end_code     = classify(c);
      end
      return st;
   endfunction

   // One character through the parse phases; emits at most one result.
   function automatic step_type process_char(input phase_type ph, input logic [8:0] c,
                                             input cfg_type cfg);
      step_type st;
      step_type data;
      logic     ends_unq;
      ends_unq = (c == CH_COMMA) || (cfg.table_mode && c == delim_char(cfg.delimiter_select));
      data          = '0;
      data.phase    = ph;
      data.emit     = 1'b1;
      data.res.out_byte = c[7:0];
      st       = '0;
      st.phase = ph;
      unique case (ph)
         PH_LEAD: begin
            if (c == CH_EOF) begin
               st = finish_step(c, cfg);
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
               st.phase = PH_LEAD;
            end else if (c == CH_QUOTE) begin
               st.phase = PH_QUO;
            end else if (ends_unq) begin
               st = finish_step(c, cfg);
            end else begin
               st       = data;
               st.phase = PH_UNQ;
            end
         end
         PH_UNQ: begin
            if (c == CH_EOF || ends_unq)
               st = finish_step(c, cfg);
            else
               st = data;
         end
         PH_QUO: begin
            if (c == CH_EOF)
               st = finish_step(c, cfg);
            else if (c == CH_QUOTE)
               st.phase = PH_QSEEN;
            else
               st = data;
         end
         PH_QSEEN: begin
            if (c == CH_QUOTE) begin
               st       = data;
               st.phase = PH_QUO;
            end else begin
               st = finish_step(c, cfg);
            end
         end
         PH_TRAIL: st = finish_step(c, cfg);
         default:  st = finish_step(c, cfg);
      endcase
      return st;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dfp_queue.sv =====
// Short result queue between the parse front and the output back.
`default_nettype none

module dfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dfp_pkg::entry_type    push_data,
   input  logic                  pop,
   output dfp_pkg::entry_type    head_data,
   output dfp_pkg::q_status_type status
);
   import dfp_pkg::*;

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign head_data        = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ===== rtl/dfp_front.sv =====
// Parse front: control registers, parse state and per-byte result building.
`default_nettype none

module dfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [1:0]            csr_data,
   input  dfp_pkg::q_status_type q_status,
   output logic                  q_push,
   output dfp_pkg::entry_type    q_data
);
   import dfp_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   phase_type phase_ff, phase_in;
   logic      esc_pend_ff, esc_pend_in;

   logic       accept;
   logic [8:0] c;
   logic [7:0] esc_byte;
   logic       in_body;
   step_type   s1, s2;
   logic       use_s2;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tlast ? CH_EOF : {1'b0, req_tdata};
   assign esc_byte   = esc_decode(c);
   assign in_body    = (phase_ff == PH_UNQ) || (phase_ff == PH_QUO) || (phase_ff == PH_QSEEN);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ESCAPES: cfg_in.escapes_enabled  = csr_data[0];
            CSR_TABLE:   cfg_in.table_mode       = csr_data[0];
            CSR_DELIM:   cfg_in.delimiter_select = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1          = '0;
      s1.phase    = phase_ff;
      s2          = '0;
      s2.phase    = phase_ff;
      use_s2      = 1'b0;
      esc_pend_in = esc_pend_ff;
      if (esc_pend_ff) begin
         esc_pend_in = 1'b0;
         if (esc_byte != ESC_NONE) begin
            s1 = process_char(phase_ff, {1'b0, esc_byte}, cfg_ff);
         end else begin
            // unknown escape: pass the backslash, then reprocess the byte
            s1     = process_char(phase_ff, CH_BSLASH, cfg_ff);
            s2     = process_char(s1.phase, c, cfg_ff);
            use_s2 = 1'b1;
         end
      end else if (cfg_ff.escapes_enabled && c == CH_BSLASH && in_body) begin
         esc_pend_in = 1'b1;
      end else begin
         s1 = process_char(phase_ff, c, cfg_ff);
      end
      phase_in = use_s2 ? s2.phase : s1.phase;
   end

   always_comb begin
      q_data          = '0;
      q_data.r0       = s1.emit ? s1.res : s2.res;
      q_data.r1_valid = s1.emit && use_s2 && s2.emit;
      q_data.r1       = s2.res;
      q_push          = accept && (s1.emit || (use_s2 && s2.emit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escapes_enabled  <= 1'b0;
         cfg_ff.table_mode       <= 1'b0;
         cfg_ff.delimiter_select <= DELIM_COMMA;
         phase_ff                <= PH_LEAD;
         esc_pend_ff             <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            phase_ff    <= phase_in;
            esc_pend_ff <= esc_pend_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dfp_back.sv =====
// Output back: splits queue entries into single results behind an output register.
`default_nettype none

module dfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dfp_pkg::q_status_type q_status,
   input  dfp_pkg::entry_type    q_data,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [3:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import dfp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   res_type out_res_ff, out_res_in;
   logic    out_last_ff, out_last_in;
   logic    hold_valid_ff, hold_valid_in;
   res_type hold_res_ff, hold_res_in;
   logic    advance;

   assign advance = !out_valid_ff || rsp_tready;
   assign q_pop   = advance && !hold_valid_ff && q_status.not_empty;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      out_last_in   = out_last_ff;
      hold_valid_in = hold_valid_ff;
      hold_res_in   = hold_res_ff;
      if (advance) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = hold_res_ff;
            out_last_in   = 1'b1;
            hold_valid_in = 1'b0;
         end else if (q_status.not_empty) begin
            out_valid_in  = 1'b1;
            out_res_in    = q_data.r0;
            out_last_in   = !q_data.r1_valid;
            hold_valid_in = q_data.r1_valid;
            hold_res_in   = q_data.r1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      out_last_ff <= out_last_in;
      hold_res_ff <= hold_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.out_byte;
   assign rsp_tuser  = {out_res_ff.end_code, out_res_ff.is_field_end};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/delimited_field_parser.sv =====
// Top level of the delimited field parser: front, result queue and back.
// An accepted byte's results pass through the result queue, then the output register, to rsp.
// Throughput: one byte per cycle, stalling only once the four-entry queue fills; a byte with
//   two results (an unknown escape whose byte also yields a result) sends them out in turn.
// Sustained output is one result per cycle while rsp is ready; the queue absorbs stalls.
// Reset: synchronous; parse state to leading skip, registers to defaults, queue emptied.
`default_nettype none

module delimited_field_parser (
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_input
   // results
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [3:0] rsp_tuser,   // [0] is_field_end, [3:1] end_code
   output logic       rsp_tlast,   // last_of_run
   // control register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,   // 0 escapes_enabled, 1 table_mode, 2 delimiter_select
   input  logic [1:0] csr_data
);
   import dfp_pkg::*;

   q_status_type q_status;
   entry_type    push_data;
   entry_type    head_data;
   logic         q_push;
   logic         q_pop;

   // Front: classify each byte against the parse phase and build its results.
   dfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (push_data)
   );

   // Queue: decouple the front from output backpressure; bytes without results skip it.
   dfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .head_data (head_data),
      .status    (q_status)
   );

   // Back: hand out one result per cycle while rsp is ready and mark the last of each byte's run.
   dfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_data     (head_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/dfp_checker.sv =====
// Port-level checks of the delimited field parser and their bind.
`default_nettype none
`include "assert_macros.svh"

module dfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [3:0] rsp_tuser,
   input logic       rsp_tlast
);

   // hold a stalled result
   `DFP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // nothing is shown right after reset
   `DFP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // a field end carries a zero byte
   `DFP_ASSERT(a_end_byte_zero, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'd0)

   // a data byte carries no terminator code
   `DFP_ASSERT(a_data_code_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[3:1] == 3'd0)

   // terminator code stays within its defined set
   `DFP_ASSERT(a_code_range, clock, reset, rsp_tvalid |-> rsp_tuser[3:1] != 3'd5 && rsp_tuser[3:1] != 3'd6 && rsp_tuser[3:1] != 3'd7)

endmodule

bind delimited_field_parser dfp_checker u_dfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/field_stream_checker.sv =====
// Checker for the delimited field parser: predicts results from accepted items and compares.
`default_nettype none

module field_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [3:0] rsp_tuser,
   input  logic       rsp_tlast,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [1:0] csr_data,
   output int         mismatch_count,
   output int         pending_count,
   output int         results_seen
);
   import dfp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       field_end;
      logic [2:0] code;
      logic       last_of_run;
   } field_result_type;

   field_result_type expected_fields[$];
   field_result_type item_results[$];

   // shadow of the control registers and the parse state
   logic       esc_on;
   logic       table_on;
   logic [1:0] delim_sel;
   phase_type  parse_phase;
   logic       esc_pending;

   function automatic void add_result(input logic [7:0] b, input logic fe,
                                      input logic [2:0] code);
      field_result_type r;
      r.data        = b;
      r.field_end   = fe;
      r.code        = code;
      r.last_of_run = 1'b0;
      if (item_results.size() < 2)
         item_results.push_back(r);
   endfunction

   // Character right after a field body or a trailing blank.
   function automatic void close_field(input logic [8:0] c);
      logic       tab_delim;
      logic [2:0] code;
      tab_delim = table_on && (delim_sel == DELIM_TAB);
      if (c == CH_SPACE || (c == CH_TAB && !tab_delim)) begin
         parse_phase = PH_TRAIL;
      end else begin
         case (c)
            CH_COMMA: code = END_COMMA;
            CH_SEMI:  code = END_SEMI;
            CH_TAB:   code = END_TAB;
            CH_EOF:   code = END_EOI;
            default:  code = END_OTHER;
         endcase
         add_result(8'h00, 1'b1, code);
         parse_phase = PH_LEAD;
      end
   endfunction

   function automatic void parse_char(input logic [8:0] c);
      logic [8:0] table_delim;
      logic       delim_hit;
      case (delim_sel)
         DELIM_LF:   table_delim = CH_LF;
         DELIM_SEMI: table_delim = CH_SEMI;
         DELIM_TAB:  table_delim = CH_TAB;
         default:    table_delim = CH_COMMA;
      endcase
      delim_hit = (c == CH_COMMA) || (table_on && c == table_delim);
      case (parse_phase)
         PH_LEAD: begin
            if (c == CH_EOF) begin
               close_field(c);
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
               parse_phase = PH_LEAD;
            end else if (c == CH_QUOTE) begin
               parse_phase = PH_QUO;
            end else if (delim_hit) begin
               close_field(c);
            end else begin
               add_result(c[7:0], 1'b0, END_OTHER);
               parse_phase = PH_UNQ;
            end
         end
         PH_UNQ: begin
            if (c == CH_EOF || delim_hit)
               close_field(c);
            else
               add_result(c[7:0], 1'b0, END_OTHER);
         end
         PH_QUO: begin
            if (c == CH_EOF)
               close_field(c);
            else if (c == CH_QUOTE)
               parse_phase = PH_QSEEN;
            else
               add_result(c[7:0], 1'b0, END_OTHER);
         end
         PH_QSEEN: begin
            if (c == CH_QUOTE) begin
               add_result(c[7:0], 1'b0, END_OTHER);
               parse_phase = PH_QUO;
            end else begin
               close_field(c);
            end
         end
         default: close_field(c);
      endcase
   endfunction

   // Work out the results of one accepted item and queue them.
   function automatic void parse_item(input logic [7:0] b, input logic eoi);
      logic [8:0] c;
      logic [7:0] decoded;
      c = eoi ? CH_EOF : {1'b0, b};
      item_results.delete();
      if (esc_pending) begin
         esc_pending = 1'b0;
         case (c)
            CH_LOW_B:  decoded = ESC_BS;
            CH_LOW_F:  decoded = ESC_FF;
            CH_LOW_N:  decoded = ESC_LF;
            CH_LOW_T:  decoded = ESC_HT;
            CH_LOW_R:  decoded = ESC_CR;
            CH_LOW_V:  decoded = ESC_VT;
            CH_BSLASH: decoded = CH_BSLASH[7:0];
            default:   decoded = ESC_NONE;
         endcase
         if (decoded != ESC_NONE) begin
            parse_char({1'b0, decoded});
         end else begin
            // unknown escape: pass the backslash, then handle the character afresh
            parse_char(CH_BSLASH);
            parse_char(c);
         end
      end else if (esc_on && c == CH_BSLASH &&
                   (parse_phase == PH_UNQ || parse_phase == PH_QUO ||
                    parse_phase == PH_QSEEN)) begin
         esc_pending = 1'b1;
      end else begin
         parse_char(c);
      end
      if (item_results.size() > 0)
         item_results[item_results.size() - 1].last_of_run = 1'b1;
      foreach (item_results[i])
         expected_fields.push_back(item_results[i]);
   endfunction

   always @(posedge clock) begin
      field_result_type exp_r;
      if (reset) begin
         esc_on         = 1'b0;
         table_on       = 1'b0;
         delim_sel      = DELIM_COMMA;
         parse_phase    = PH_LEAD;
         esc_pending    = 1'b0;
         mismatch_count = 0;
         results_seen   = 0;
         expected_fields.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ESCAPES: esc_on    = csr_data[0];
               CSR_TABLE:   table_on  = csr_data[0];
               CSR_DELIM:   delim_sel = csr_data;
               default:     ;
            endcase
         end
         if (req_tvalid && req_tready)
            parse_item(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            results_seen = results_seen + 1;
            if (expected_fields.size() == 0) begin
               $error("unexpected result: out_byte %0h, tuser %0h, tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count = mismatch_count + 1;
            end else begin
               exp_r = expected_fields.pop_front();
               if (rsp_tdata !== exp_r.data) begin
                  $error("out_byte mismatch: expected %0h, actual %0h", exp_r.data, rsp_tdata);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_tuser[0] !== exp_r.field_end) begin
                  $error("is_field_end mismatch: expected %0b, actual %0b",
                         exp_r.field_end, rsp_tuser[0]);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_tuser[3:1] !== exp_r.code) begin
                  $error("end_code mismatch: expected %0d, actual %0d",
                         exp_r.code, rsp_tuser[3:1]);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_tlast !== exp_r.last_of_run) begin
                  $error("last_of_run mismatch: expected %0b, actual %0b",
                         exp_r.last_of_run, rsp_tlast);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
      pending_count = expected_fields.size();
   end

endmodule

`default_nettype wire

// ===== tb/delimited_field_parser_tb.sv =====
// Testbench top of the delimited field parser: stimulus, idling and final verdict.
`default_nettype none

module delimited_field_parser_tb;
   import dfp_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] in_byte
   logic       req_tlast;   // end_of_input
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic [3:0] rsp_tuser;   // [0] is_field_end, [3:1] end_code
   logic       rsp_tlast;   // last_of_run
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [1:0] csr_data;

   int mismatch_count;
   int pending_count;
   int results_seen;

   // idling rates in percent, changed per phase
   int gap_pct;
   int stall_pct;
   int items_sent;
   int settings_applied;

   delimited_field_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   field_stream_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .results_seen   (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: far beyond the slowest correct run (every item with two
   // results, each held by a full receiver stall).
   initial begin
      #12_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver side: stall in bursts, at a rate set per phase.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left = stall_left - 1;
         end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Offer one item; hold it until the block takes it. Valid stays high
   // afterwards so back-to-back items flow at one per cycle while the block is ready.
   task automatic send_item(input logic [7:0] b, input logic eoi);
      int gap;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent = items_sent + 1;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   // End of input carries a random byte, which the block must ignore.
   task automatic send_eoi();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drain all expected results, let items with no result leave the pipe,
   // then write every register.
   task automatic apply_settings(input logic esc, input logic tbl, input logic [1:0] delim);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      write_reg(CSR_ESCAPES, {1'b0, esc});
      write_reg(CSR_TABLE, {1'b0, tbl});
      write_reg(CSR_DELIM, delim);
      settings_applied = settings_applied + 1;
   endtask

   // Weighted character: mostly plain text, with a good share of the
   // characters that steer the parser.
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
      if (r < 48) return 8'h30 + 8'($urandom_range(0, 9));
      if (r < 56) return CH_BSLASH[7:0];
      if (r < 64) begin
         case ($urandom_range(0, 5))
            0: return CH_LOW_B[7:0];
            1: return CH_LOW_F[7:0];
            2: return CH_LOW_N[7:0];
            3: return CH_LOW_T[7:0];
            4: return CH_LOW_R[7:0];
            default: return CH_LOW_V[7:0];
         endcase
      end
      if (r < 70) return CH_QUOTE[7:0];
      if (r < 75) return CH_SPACE[7:0];
      if (r < 79) return CH_TAB[7:0];
      if (r < 82) return CH_COMMA[7:0];
      if (r < 85) return CH_SEMI[7:0];
      if (r < 88) return CH_LF[7:0];
      if (r < 90) return CH_CR[7:0];
      return 8'($urandom_range(0, 255));
   endfunction

   // One field: leading blanks, quoted or bare body, trailing blanks,
   // terminator. Some records are replaced by raw noise instead.
   task automatic send_record();
      logic [7:0] ch;
      int         len;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 9) == 0)
               send_eoi();
            else
               send_item(8'($urandom_range(0, 255)), 1'b0);
         end
         return;
      end
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 3))
            0: send_item(CH_SPACE[7:0], 1'b0);
            1: send_item(CH_TAB[7:0], 1'b0);
            2: send_item(CH_CR[7:0], 1'b0);
            default: send_item(CH_LF[7:0], 1'b0);
         endcase
      end
      len = $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) begin
         send_item(CH_QUOTE[7:0], 1'b0);
         repeat (len) begin
            ch = pick_char();
            send_item(ch, 1'b0);
            // mostly double a quote so the field stays open
            if (ch == CH_QUOTE[7:0] && $urandom_range(0, 3) != 0)
               send_item(ch, 1'b0);
         end
         send_item(CH_QUOTE[7:0], 1'b0);
      end else begin
         repeat (len) send_item(pick_char(), 1'b0);
      end
      repeat ($urandom_range(0, 1))
         send_item($urandom_range(0, 1) ? CH_SPACE[7:0] : CH_TAB[7:0], 1'b0);
      case ($urandom_range(0, 9))
         0, 1, 2: send_item(CH_COMMA[7:0], 1'b0);
         3, 4:    send_item(CH_SEMI[7:0], 1'b0);
         5:       send_item(CH_TAB[7:0], 1'b0);
         6:       send_item(CH_LF[7:0], 1'b0);
         7:       send_item(pick_char(), 1'b0);
         8:       send_eoi();
         default: send_item(CH_COMMA[7:0], 1'b0);
      endcase
   endtask

   initial begin
      logic [1:0] delim;
      int         target;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = 8'h00;
      req_tlast        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_ESCAPES;
      csr_data         = 2'd0;
      gap_pct          = 0;
      stall_pct        = 0;
      items_sent       = 0;
      settings_applied = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset settings: blanks before a field, quoted field with a
      // doubled quote, trailing space then comma, extreme bytes, newline as
      // plain data, end of input closing that field, then one with no field open.
      send_text("  \"q\"\"x\" ,");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_LF[7:0], 1'b0);
      send_eoi();
      send_eoi();

      // Escapes on, tab as table delimiter: known escape, unknown escape,
      // tab ending a field, then leave an escape open.
      apply_settings(1'b1, 1'b1, DELIM_TAB);
      send_text("a\\n\\q\tb\\");

      // Switch escapes off while one is pending: it is still decoded.
      apply_settings(1'b0, 1'b0, DELIM_COMMA);
      send_text("t");
      send_eoi();

      // Random phases: extremes of the settings first, then random ones.
      // Idling varies per phase; the final phase runs without any.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: apply_settings(1'b0, 1'b0, DELIM_LF);
            1: apply_settings(1'b1, 1'b1, DELIM_TAB);
            2: apply_settings(1'b1, 1'b1, DELIM_LF);
            3: apply_settings(1'b0, 1'b1, DELIM_SEMI);
            4: apply_settings(1'b1, 1'b0, DELIM_COMMA);
            default: begin
               delim = 2'($urandom_range(0, 3));
               apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), delim);
            end
         endcase
         if (ph == 7) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
         end
         target = items_sent + 150;
         while (items_sent < target) send_record();
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      // let any stray result surface before the verdict
      repeat (20) @(negedge clock);

      $display("Run covered %0d input items and %0d checked results over %0d register settings.",
               items_sent, results_seen, settings_applied);
      $display("Quoted and bare fields, escapes, table delimiters and end of input were mixed.");
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/dfp_pkg.sv
rtl/dfp_queue.sv
rtl/dfp_front.sv
rtl/dfp_back.sv
rtl/delimited_field_parser.sv
rtl/dfp_checker.sv
tb/field_stream_checker.sv
tb/delimited_field_parser_tb.sv
